// ----- sv/alle_pkg.sv -----
// ---------------------------------------------------------------------------
// alle_pkg: shared definitions for the array linked list engine
// Slot indexes, link encoding, FSM states, handshake codes and the
// memory access bundles passed between the engine and its link store.
// ---------------------------------------------------------------------------
package alle_pkg;

    localparam int ENTRIES    = 16;
    localparam int VALUE_BITS = 32;
    localparam int LOC_W      = 4;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LINK_W     = $clog2(ENTRIES + 1);

    localparam int IN_W        = LOC_W + VALUE_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 1 + 3 * LINK_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [LOC_W-1:0]  loc_t;

    localparam link_t NULL_LINK = link_t'(ENTRIES);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS1,
        ST_INS2,
        ST_DEL1,
        ST_DEL2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic en;
        idx_t nx_addr_a;
        idx_t nx_addr_b;
        idx_t pv_addr;
    } link_rd_t;

    typedef struct packed {
        logic  nx_we;
        idx_t  nx_addr;
        link_t nx_data;
        logic  pv_we;
        idx_t  pv_addr;
        link_t pv_data;
    } link_wr_t;

    function automatic logic is_slot(input link_t l);
        return (l < link_t'(ENTRIES));
    endfunction

    // Next links after reset: a chain from slot 1 to the last slot; slot 0 is alone.
    function automatic link_t next_reset(input idx_t i);
        link_t r;
        if (i == idx_t'(0) || i == idx_t'(ENTRIES - 1)) begin
            r = NULL_LINK;
        end else begin
            r = link_t'(i) + link_t'(1);
        end
        return r;
    endfunction

    function automatic link_t prev_reset(input idx_t i);
        link_t r;
        if (i == idx_t'(0)) begin
            r = NULL_LINK;
        end else begin
            r = link_t'(i) - link_t'(1);
        end
        return r;
    endfunction

endpackage

// ----- sv/alle_link_mem.sv -----
// ---------------------------------------------------------------------------
// alle_link_mem: next and previous link store
// Two synchronous memories with registered read data. The next store has
// two read ports, the previous store one. Per-entry valid bits stand in
// for the reset chains until an entry is first written.
// ---------------------------------------------------------------------------
module alle_link_mem
    import alle_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  link_rd_t rd,
    input  link_wr_t wr,
    output link_t    nx_rdata_a,
    output link_t    nx_rdata_b,
    output link_t    pv_rdata
);

    link_t nx_mem [ENTRIES];
    link_t pv_mem [ENTRIES];

    logic [ENTRIES-1:0] nx_vld_reg;
    logic [ENTRIES-1:0] pv_vld_reg;

    link_t nx_a_data_reg;
    link_t nx_b_data_reg;
    link_t pv_data_reg;
    logic  nx_a_vld_reg;
    logic  nx_b_vld_reg;
    logic  pv_vld_q_reg;
    idx_t  nx_a_addr_reg;
    idx_t  nx_b_addr_reg;
    idx_t  pv_addr_reg;

    always_ff @(posedge aclk) begin
        if (wr.nx_we) begin
            nx_mem[wr.nx_addr] <= wr.nx_data;
        end
        if (wr.pv_we) begin
            pv_mem[wr.pv_addr] <= wr.pv_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_vld_reg <= '0;
            pv_vld_reg <= '0;
        end else begin
            if (wr.nx_we) begin
                nx_vld_reg[wr.nx_addr] <= 1'b1;
            end
            if (wr.pv_we) begin
                pv_vld_reg[wr.pv_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            nx_a_data_reg <= nx_mem[rd.nx_addr_a];
            nx_b_data_reg <= nx_mem[rd.nx_addr_b];
            pv_data_reg   <= pv_mem[rd.pv_addr];
            nx_a_vld_reg  <= nx_vld_reg[rd.nx_addr_a];
            nx_b_vld_reg  <= nx_vld_reg[rd.nx_addr_b];
            pv_vld_q_reg  <= pv_vld_reg[rd.pv_addr];
            nx_a_addr_reg <= rd.nx_addr_a;
            nx_b_addr_reg <= rd.nx_addr_b;
            pv_addr_reg   <= rd.pv_addr;
        end
    end

    assign nx_rdata_a = nx_a_vld_reg ? nx_a_data_reg : next_reset(nx_a_addr_reg);
    assign nx_rdata_b = nx_b_vld_reg ? nx_b_data_reg : next_reset(nx_b_addr_reg);
    assign pv_rdata   = pv_vld_q_reg ? pv_data_reg   : prev_reset(pv_addr_reg);

endmodule

// ----- sv/array_linked_list_engine_unit.sv -----
// ---------------------------------------------------------------------------
// array_linked_list_engine_unit: doubly linked list in slot memories
// Inserts after or deletes a slot and reports the list and free heads.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command item: s_tuser selects insert or delete,
//   s_tdata carries the slot location and the value to store. The m_
//   channel returns one result item per command with the status, the slot
//   taken by an insert, and the list head and free list head afterwards.
//   An insert or delete goes from acceptance through one read of the link
//   memories, the write states (each link memory has one write port) and
//   the result load into the output register. A refused insert goes from
//   the read straight to the result load; m_tvalid rises with that load.
//   The engine works on one item at a time; a new item is accepted as soon
//   as the previous result sits in the output register, even while the
//   receiver holds m_tready low. A stalled result blocks only the result
//   load of the following item. After reset slot 0 is the list head with
//   null links and slots 1 and up form the free list; valid bits supply
//   these chains until entries are written, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module array_linked_list_engine_unit
    import alle_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] location, [35:4] data, upper bits zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] status, [5:1] slot, [10:6] head_index, [15:11] free_index
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic  kind_reg;
    idx_t  loc_reg;
    link_t fslot_reg;
    link_t after_reg, after_next;
    link_t head_reg, head_next;
    link_t free_reg, free_next;
    logic  status_reg, status_next;
    link_t taken_reg, taken_next;
    logic  m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    link_rd_t rd;
    link_wr_t wr;
    link_t    nx_rdata_a;
    link_t    nx_rdata_b;
    link_t    pv_rdata;

    logic signed [VALUE_BITS-1:0] val_mem [ENTRIES];

    loc_t s_loc;
    logic s_accept;
    logic loc_ok;
    logic ins_go;
    logic out_free;

    assign s_loc    = s_tdata[LOC_W-1:0];
    assign s_accept = s_tvalid && s_tready;
    assign loc_ok   = (int'(s_loc) < ENTRIES);
    assign ins_go   = (s_tuser == KIND_INSERT) && loc_ok && is_slot(free_reg);
    assign out_free = !m_valid_reg || m_tready;

    alle_link_mem u_link_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd         (rd),
        .wr         (wr),
        .nx_rdata_a (nx_rdata_a),
        .nx_rdata_b (nx_rdata_b),
        .pv_rdata   (pv_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!loc_ok) begin
                        state_next = ST_OUT;
                    end else if (s_tuser == KIND_DELETE) begin
                        state_next = ST_DEL1;
                    end else if (is_slot(free_reg)) begin
                        state_next = ST_INS1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INS1: state_next = ST_INS2;
            ST_INS2: state_next = ST_OUT;
            ST_DEL1: state_next = ST_DEL2;
            ST_DEL2: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        rd           = '0;
        wr           = '0;
        after_next   = after_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        status_next  = status_reg;
        taken_next   = taken_reg;
        case (state_reg)
            ST_IDLE: begin
                // No item is taken while reset is held.
                s_tready      = aresetn;
                rd.en         = s_accept;
                rd.nx_addr_a  = idx_t'(free_reg);
                rd.nx_addr_b  = idx_t'(s_loc);
                rd.pv_addr    = idx_t'(s_loc);
                status_next   = (s_tuser == KIND_INSERT && loc_ok && !is_slot(free_reg))
                                ? STATUS_FULL : STATUS_DONE;
                taken_next    = ins_go ? free_reg : NULL_LINK;
            end
            ST_INS1: begin
                // New slot takes the old successor of location and points back to it.
                wr.nx_we   = 1'b1;
                wr.nx_addr = idx_t'(fslot_reg);
                wr.nx_data = nx_rdata_b;
                wr.pv_we   = 1'b1;
                wr.pv_addr = idx_t'(fslot_reg);
                wr.pv_data = link_t'(loc_reg);
                free_next  = nx_rdata_a;
                after_next = nx_rdata_b;
            end
            ST_INS2: begin
                wr.nx_we   = 1'b1;
                wr.nx_addr = loc_reg;
                wr.nx_data = fslot_reg;
                wr.pv_we   = is_slot(after_reg);
                wr.pv_addr = idx_t'(after_reg);
                wr.pv_data = fslot_reg;
            end
            ST_DEL1: begin
                if (head_reg == link_t'(loc_reg)) begin
                    head_next = nx_rdata_b;
                end else begin
                    wr.nx_we = is_slot(pv_rdata);
                end
                wr.nx_addr = idx_t'(pv_rdata);
                wr.nx_data = nx_rdata_b;
                wr.pv_we   = is_slot(nx_rdata_b);
                wr.pv_addr = idx_t'(nx_rdata_b);
                wr.pv_data = pv_rdata;
            end
            ST_DEL2: begin
                // The deleted slot becomes the head of the free list.
                wr.nx_we   = 1'b1;
                wr.nx_addr = loc_reg;
                wr.nx_data = free_reg;
                free_next  = link_t'(loc_reg);
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept && ins_go) begin
            val_mem[idx_t'(free_reg)] <= s_tdata[LOC_W +: VALUE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= s_tuser;
            loc_reg   <= idx_t'(s_loc);
            fslot_reg <= free_reg;
        end
        after_reg  <= after_next;
        status_reg <= status_next;
        taken_reg  <= taken_next;
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= OUT_TDATA_W'({free_reg, head_reg, taken_reg, status_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= link_t'(0);
            free_reg    <= (ENTRIES > 1) ? link_t'(1) : NULL_LINK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != ST_IDLE)
        else $error("engine stayed idle after accepting an item");

    a_insert_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && ins_go) |=> (state_reg == ST_INS1 && kind_reg == KIND_INSERT))
        else $error("insert with a free slot did not start the insert sequence");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result not loaded when the output register was free");

    a_full_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && status_reg == STATUS_FULL) |-> taken_reg == NULL_LINK)
        else $error("refused insert reports a taken slot");

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= NULL_LINK && head_reg <= NULL_LINK)
        else $error("head or free link outside the slot range");
`endif

endmodule

// ----- test/list_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// list_checker: result predictor and comparator for the linked list engine
// Keeps its own copy of the slot links, list head and free list head. It
// works out the result of every command item accepted on the s_ channel and
// compares each result item on the m_ channel with the oldest one owed.
// ---------------------------------------------------------------------------
module list_checker
    import alle_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     results_owed
);

    typedef struct packed {
        logic  status;
        link_t slot;
        link_t head;
        link_t free_idx;
    } list_result_t;

    link_t                 next_of      [ENTRIES];
    link_t                 prev_of      [ENTRIES];
    logic [VALUE_BITS-1:0] stored_value [ENTRIES];
    link_t                 head_slot;
    link_t                 free_head;

    list_result_t owed_q[$];
    list_result_t want;
    list_result_t got;
    int           errs = 0;

    function automatic void clear_list();
        for (int i = 0; i < ENTRIES; i++) begin
            next_of[i]      = (i == 0 || i == ENTRIES - 1) ? NULL_LINK : link_t'(i + 1);
            prev_of[i]      = (i == 0) ? NULL_LINK : link_t'(i - 1);
            stored_value[i] = '0;
        end
        head_slot = link_t'(0);
        free_head = (ENTRIES > 1) ? link_t'(1) : NULL_LINK;
    endfunction

    // Applies one command to the list copy and returns the result it causes.
    function automatic list_result_t apply_command(input logic kind, input loc_t loc,
                                                   input logic [VALUE_BITS-1:0] value);
        list_result_t r;
        link_t        taken;
        link_t        succ;
        link_t        pred;
        idx_t         at;
        r.status = STATUS_DONE;
        r.slot   = NULL_LINK;
        at       = idx_t'(loc);
        // Locations beyond the slot range leave everything unchanged.
        if (link_t'(loc) < link_t'(ENTRIES)) begin
            if (kind == KIND_INSERT) begin
                if (free_head < link_t'(ENTRIES)) begin
                    taken                       = free_head;
                    r.slot                      = taken;
                    free_head                   = next_of[idx_t'(taken)];
                    next_of[idx_t'(taken)]      = next_of[at];
                    prev_of[idx_t'(taken)]      = link_t'(at);
                    succ                        = next_of[at];
                    if (succ < link_t'(ENTRIES)) begin
                        prev_of[idx_t'(succ)] = taken;
                    end
                    next_of[at]                 = taken;
                    stored_value[idx_t'(taken)] = value;
                end else begin
                    r.status = STATUS_FULL;
                end
            end else begin
                if (link_t'(at) == head_slot) begin
                    head_slot = next_of[at];
                end else begin
                    pred = prev_of[at];
                    if (pred < link_t'(ENTRIES)) begin
                        next_of[idx_t'(pred)] = next_of[at];
                    end
                end
                succ = next_of[at];
                if (succ < link_t'(ENTRIES)) begin
                    prev_of[idx_t'(succ)] = prev_of[at];
                end
                next_of[at] = free_head;
                free_head   = link_t'(at);
            end
        end
        r.head     = head_slot;
        r.free_idx = free_head;
        return r;
    endfunction

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_list();
            owed_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status   = m_tdata[0];
                got.slot     = m_tdata[LINK_W:1];
                got.head     = m_tdata[2*LINK_W:LINK_W+1];
                got.free_idx = m_tdata[3*LINK_W:2*LINK_W+1];
                if (owed_q.size() == 0) begin
                    $error("result item arrived with no command outstanding");
                    errs++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("slot", want.slot, got.slot);
                    check_field("head_index", want.head, got.head);
                    check_field("free_index", want.free_idx, got.free_idx);
                end
            end
            if (s_tvalid && s_tready) begin
                owed_q.push_back(apply_command(s_tuser, s_tdata[LOC_W-1:0],
                                               s_tdata[LOC_W +: VALUE_BITS]));
            end
        end
        mismatch_count <= errs;
        results_owed   <= owed_q.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the array linked list engine
// Drives insert and delete commands with random gaps and result stalls.
// Most commands keep the list well formed; a closing phase empties the
// list and then sends unchecked locations. The checker predicts results.
// ---------------------------------------------------------------------------
module tb_top
    import alle_pkg::*;
();

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [3:0] location, [35:4] data, upper bits zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    // [0] kind
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] status, [5:1] slot, [10:6] head_index, [15:11] free_index
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_owed;

    bit calm       = 1'b0;
    bit held_off   = 1'b0;
    int sent_count = 0;

    // Shadow of a well formed list: slots in list order and the free stack.
    int order_q[$];
    int free_q[$];

    array_linked_list_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input logic kind, input loc_t loc,
                             input logic [VALUE_BITS-1:0] value);
        if (!calm && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, value, loc};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Inserts after the slot at list position pos; refused when nothing is free.
    task automatic insert_after(input int pos, input logic [VALUE_BITS-1:0] value);
        send_item(KIND_INSERT, loc_t'(order_q[pos]), value);
        if (free_q.size() != 0) begin
            order_q.insert(pos + 1, free_q.pop_front());
        end
    endtask

    task automatic remove_at(input int pos);
        int s;
        s = order_q[pos];
        send_item(KIND_DELETE, loc_t'(s), $urandom());
        order_q.delete(pos);
        free_q.push_front(s);
    endtask

    // Receiver: random stalls, one long hold-off, and no stalls at the end.
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!held_off && sent_count >= 400) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if ($urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(8, 1)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [VALUE_BITS-1:0] extreme_vals [4];
        int                    pos;
        bit                    do_insert;
        extreme_vals[0] = 32'h7FFF_FFFF;
        extreme_vals[1] = 32'h8000_0000;
        extreme_vals[2] = 32'h0000_0000;
        extreme_vals[3] = 32'hFFFF_FFFF;
        order_q.push_back(0);
        for (int i = 1; i < ENTRIES; i++) begin
            free_q.push_back(i);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot, alternating between the head and the tail.
        for (int i = 0; i < ENTRIES - 1; i++) begin
            insert_after((i % 2 == 1) ? order_q.size() - 1 : 0,
                         (i < 4) ? extreme_vals[i] : $urandom());
        end
        // The free list is empty now, so this insert must be refused.
        send_item(KIND_INSERT, loc_t'(ENTRIES - 1), 32'h5A5A_A5A5);
        remove_at(0);
        pos = 0;
        for (int i = 0; i < order_q.size(); i++) begin
            if (order_q[i] == ENTRIES - 1) pos = i;
        end
        remove_at(pos);
        remove_at(order_q.size() - 1);
        insert_after(0, $urandom());
        insert_after(order_q.size() - 1, $urandom());

        repeat (1680) begin
            if (free_q.size() == 0) begin
                do_insert = ($urandom_range(3) == 0);
            end else if (order_q.size() == 1) begin
                do_insert = 1'b1;
            end else begin
                do_insert = 1'($urandom_range(1));
            end
            if (do_insert) begin
                insert_after($urandom_range(order_q.size() - 1), $urandom());
            end else begin
                remove_at($urandom_range(order_q.size() - 1));
            end
        end

        // Empty the list so the head goes null, then use locations outside it.
        while (order_q.size() > 0) begin
            remove_at(0);
        end
        send_item(KIND_DELETE, loc_t'(3), $urandom());
        send_item(KIND_INSERT, loc_t'(9), $urandom());
        send_item(KIND_INSERT, loc_t'(0), $urandom());
        send_item(KIND_DELETE, loc_t'(ENTRIES - 1), $urandom());

        for (int i = 0; i < 250; i++) begin
            if (i == 150) calm = 1'b1;
            send_item(1'($urandom_range(1)), loc_t'($urandom_range(15)), $urandom());
        end
        s_tvalid <= 1'b0;

        repeat (2) @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/alle_pkg.sv
sv/alle_link_mem.sv
sv/array_linked_list_engine_unit.sv
test/list_checker.sv
test/tb_top.sv
